>>> sv/u8cp_pkg.sv
// Shared types and constants for the UTF-8 to CP1251 transcoder.
package u8cp_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_CHAR = 8'd1;

    localparam int unsigned LIMIT_W = 13;

    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST    = 13'd256;
    localparam logic [7:0]         UNKNOWN_CHAR_RST = 8'd42;

    // Lead bytes and special continuation bytes.
    localparam logic [7:0] LEAD_D0    = 8'hD0;
    localparam logic [7:0] LEAD_D1    = 8'hD1;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_E2    = 8'hE2;
    localparam logic [7:0] OFS_D0     = 8'h30;
    localparam logic [7:0] OFS_D1     = 8'h70;
    localparam logic [7:0] CP_YO_UP   = 8'hA8;
    localparam logic [7:0] CP_YO_LO   = 8'hB8;
    localparam logic [7:0] TRAIL_E2_1 = 8'h80;
    localparam logic [7:0] TRAIL_DASH = 8'h94;
    localparam logic [7:0] TRAIL_ELL  = 8'hA6;
    localparam logic [7:0] GUIL_LEFT  = 8'hAB;
    localparam logic [7:0] GUIL_RIGHT = 8'hBB;
    localparam logic [7:0] YO_UP_TR   = 8'h81;
    localparam logic [7:0] YO_LO_TR   = 8'h91;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // E2 sequence progress.
    localparam logic [1:0] E2_IDLE = 2'd0;
    localparam logic [1:0] E2_HELD = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // Results of one input beat: nchar copies of one byte, then maybe a terminator.
    typedef struct packed {
        logic [7:0] chr;
        logic [1:0] nchar;
        logic       term;
    } t_group;

endpackage

>>> sv/u8cp_decode.sv
// Per-byte decoder and string state of the transcoder.
module u8cp_decode
    import u8cp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_in_beat           i_beat,
    input  logic [LIMIT_W-1:0] i_out_limit,
    input  logic [7:0]         i_unknown_char,
    output t_group             o_group
);

    logic [7:0]         r_lead,  n_lead;
    logic [1:0]         r_e2,    n_e2;
    logic [7:0]         r_trail, n_trail;
    logic [LIMIT_W-1:0] r_count, n_count;
    logic               r_skip,  n_skip;

    logic [7:0] w_c;
    logic [1:0] w_want;
    logic [7:0] w_chr;
    logic       w_term;
    logic       w_clr;
    logic [2:0] w_ok;
    logic [1:0] w_k;

    assign w_c = i_beat.in_byte;

    // Room check for each of up to three characters in the output buffer.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ok[i] = ({1'b0, r_count} + (LIMIT_W+1)'(i + 1)) < {1'b0, i_out_limit};
        end
    end

    // Translate the byte and work out the next string state.
    always_comb begin
        n_lead  = r_lead;
        n_e2    = r_e2;
        n_trail = r_trail;
        n_skip  = r_skip;
        w_want  = 2'd0;
        w_chr   = w_c;
        w_term  = 1'b0;
        w_clr   = 1'b0;
        if (r_skip) begin
            w_clr = i_beat.in_last;
        end else if (r_lead == 8'd0 && w_c == 8'd0) begin
            // Zero byte while idle ends the string early.
            w_term = 1'b1;
            if (i_beat.in_last) begin
                w_clr = 1'b1;
            end else begin
                n_skip = 1'b1;
            end
        end else begin
            if (r_e2 == E2_HELD) begin
                n_e2   = E2_IDLE;
                n_lead = 8'd0;
                if (r_trail == TRAIL_E2_1 && w_c == TRAIL_DASH) begin
                    w_chr  = CH_DASH;
                    w_want = 2'd2;
                end else if (r_trail == TRAIL_E2_1 && w_c == TRAIL_ELL) begin
                    w_chr  = CH_DOT;
                    w_want = 2'd3;
                end else begin
                    w_chr  = i_unknown_char;
                    w_want = 2'd1;
                end
            end else if (r_lead == 8'd0) begin
                if (w_c < 8'h80) begin
                    w_want = 2'd1;
                end else begin
                    n_lead = w_c;
                end
            end else begin
                n_lead = 8'd0;
                w_want = 2'd1;
                case (r_lead)
                    LEAD_D0: begin
                        if (w_c inside {[8'h90:8'hCF]}) begin
                            w_chr = w_c + OFS_D0;
                        end else if (w_c == YO_UP_TR) begin
                            w_chr = CP_YO_UP;
                        end
                    end
                    LEAD_D1: begin
                        if (w_c inside {[8'h80:8'h8F]}) begin
                            w_chr = w_c + OFS_D1;
                        end else if (w_c == YO_LO_TR) begin
                            w_chr = CP_YO_LO;
                        end
                    end
                    LEAD_C2: begin
                        if (w_c == GUIL_LEFT || w_c == GUIL_RIGHT) begin
                            w_chr = CH_QUOTE;
                        end else begin
                            w_chr = i_unknown_char;
                        end
                    end
                    LEAD_E2: begin
                        n_lead  = r_lead;
                        n_trail = w_c;
                        n_e2    = E2_HELD;
                        w_want  = 2'd0;
                    end
                    default: begin
                        w_chr = i_unknown_char;
                    end
                endcase
            end
            if (i_beat.in_last) begin
                w_term = 1'b1;
                w_clr  = 1'b1;
            end
        end

        // Characters that still fit in the buffer.
        w_k = 2'd0;
        if (w_want >= 2'd1 && w_ok[0]) w_k = 2'd1;
        if (w_want >= 2'd2 && w_ok[1]) w_k = 2'd2;
        if (w_want == 2'd3 && w_ok[2]) w_k = 2'd3;

        n_count = r_count + LIMIT_W'(w_k);
        if (w_clr) begin
            n_lead  = 8'd0;
            n_e2    = E2_IDLE;
            n_trail = 8'd0;
            n_count = '0;
            n_skip  = 1'b0;
        end
    end

    assign o_group.chr   = w_chr;
    assign o_group.nchar = w_k;
    assign o_group.term  = w_term;

    // String state advances once per decoded beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= 8'd0;
            r_e2    <= E2_IDLE;
            r_trail <= 8'd0;
            r_count <= '0;
            r_skip  <= 1'b0;
        end else if (i_adv) begin
            r_lead  <= n_lead;
            r_e2    <= n_e2;
            r_trail <= n_trail;
            r_count <= n_count;
            r_skip  <= n_skip;
        end
    end

endmodule

>>> sv/u8cp_emit.sv
// Result register that plays out the bytes of one decoded beat.
module u8cp_emit
    import u8cp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_group    i_group,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    logic [7:0] r_chr;
    logic [1:0] r_nchar;
    logic       r_term;
    logic       w_take;
    logic       w_final;

    assign o_valid  = (r_nchar != 2'd0) || r_term;
    assign w_take   = o_valid && i_ready;
    assign w_final  = (r_nchar == 2'd1 && !r_term) || (r_nchar == 2'd0 && r_term);
    assign o_free   = !o_valid || (w_take && w_final);

    assign o_beat.out_byte = (r_nchar != 2'd0) ? r_chr : 8'd0;
    assign o_beat.out_last = (r_nchar == 2'd0) && r_term;

    // Characters go first, the terminator after them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nchar <= 2'd0;
            r_term  <= 1'b0;
        end else if (i_load) begin
            r_nchar <= i_group.nchar;
            r_term  <= i_group.term;
        end else if (w_take) begin
            if (r_nchar != 2'd0) begin
                r_nchar <= r_nchar - 2'd1;
            end else begin
                r_term <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chr <= i_group.chr;
        end
    end

endmodule

>>> sv/utf8_to_cp1251_transcoder_core.sv
// Top level of the UTF-8 to CP1251 stream transcoder.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready     | i_in (in_byte, in_last)
//  out     | out       | o_out_valid / i_out_ready   | o_out (out_byte, out_last)
//
// Each input beat is registered, decoded combinationally and handed to the result
// register, which sends one output beat per cycle while the output is ready. Plain
// bytes sustain one beat per cycle under the same condition; a beat that expands
// into more than one result stalls the input until the last of them is taken.
// Reset is synchronous and active low; it restores the register defaults and
// clears the string state. A stalled output holds the input once the input
// register is full.
module utf8_to_cp1251_transcoder_core
    import u8cp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out
);

    logic [LIMIT_W-1:0] r_out_limit;
    logic [7:0]         r_unknown_char;
    logic               r_in_valid;
    t_in_beat           r_in;

    t_group w_group;
    logic   w_free;
    logic   w_empty;
    logic   w_adv;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit    <= OUT_LIMIT_RST;
            r_unknown_char <= UNKNOWN_CHAR_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_OUT_LIMIT) begin
                r_out_limit <= i_cfg_data;
            end else if (i_cfg_index == CFG_UNKNOWN_CHAR) begin
                r_unknown_char <= i_cfg_data[7:0];
            end
        end
    end

    // A decoded beat moves on when the result register frees up or it has no results.
    assign w_empty    = (w_group.nchar == 2'd0) && !w_group.term;
    assign w_adv      = r_in_valid && (w_empty || w_free);
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    u8cp_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_beat         (r_in),
        .i_out_limit    (r_out_limit),
        .i_unknown_char (r_unknown_char),
        .o_group        (w_group)
    );

    u8cp_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && !w_empty),
        .i_group (w_group),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out)
    );

    // The terminator always carries a zero byte.
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.out_last) |-> (o_out.out_byte == 8'd0))
        else $error("terminator beat with nonzero byte");

    // Nothing is presented in the cycle after reset.
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("output valid or input blocked right after reset");

    // A held input beat that cannot move on stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("input beat lost while stalled");

    // A beat with results is only loaded when the result register frees up.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_empty) |-> w_free)
        else $error("result register overwritten");

endmodule

>>> verif/utf8_to_cp1251_transcoder_core_tb.sv
// Self-checking testbench for the UTF-8 to CP1251 transcoder core.
`timescale 1ns / 100ps

module utf8_to_cp1251_transcoder_core_tb;
    import u8cp_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_beat             in_beat = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_beat            out_beat;

    // Source beats waiting for the driver, and CP1251 beats still due from the block.
    t_in_beat  src_pending[$];
    t_out_beat cp_expected[$];

    // Shadow copy of the configuration and of the per-string decoder state.
    logic [LIMIT_W-1:0] limit_reg = OUT_LIMIT_RST;
    logic [7:0]         unknown_reg = UNKNOWN_CHAR_RST;
    logic [7:0]         pend_lead = '0;
    logic [1:0]         e2_phase = E2_IDLE;
    logic [7:0]         held_trail = '0;
    int                 chars_out = 0;
    logic               skipping = 1'b0;

    int        mismatch_count = 0;
    int        cyc = 0;
    logic      calm;
    t_out_beat want_beat;

    utf8_to_cp1251_transcoder_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // A free-running count opens one long window without gaps or stalls early in the run.
    always @(posedge clk) begin
        cyc <= cyc + 1;
    end
    assign calm = (cyc >= 300) && (cyc < 600);

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic void clear_string();
        pend_lead  = '0;
        e2_phase   = E2_IDLE;
        held_trail = '0;
        chars_out  = 0;
        skipping   = 1'b0;
    endfunction

    // A character is dropped once the output buffer holds limit-1 of them.
    function automatic void put_char(input logic [7:0] b);
        t_out_beat v;
        if (chars_out + 1 < int'(limit_reg)) begin
            v.out_byte = b;
            v.out_last = 1'b0;
            cp_expected.push_back(v);
            chars_out++;
        end
    endfunction

    function automatic void put_term();
        t_out_beat v;
        v.out_byte = 8'h00;
        v.out_last = 1'b1;
        cp_expected.push_back(v);
    endfunction

    // Works out the CP1251 beats that one accepted source beat causes.
    function automatic void transcode_beat(input t_in_beat bt);
        logic [7:0] c;
        logic [7:0] lead;
        c = bt.in_byte;
        if (skipping) begin
            if (bt.in_last)
                clear_string();
            return;
        end
        if (e2_phase == E2_HELD) begin
            e2_phase  = E2_IDLE;
            pend_lead = '0;
            if (held_trail == TRAIL_E2_1 && c == TRAIL_DASH) begin
                put_char(CH_DASH);
                put_char(CH_DASH);
            end else if (held_trail == TRAIL_E2_1 && c == TRAIL_ELL) begin
                put_char(CH_DOT);
                put_char(CH_DOT);
                put_char(CH_DOT);
            end else begin
                put_char(unknown_reg);
            end
        end else if (pend_lead == 8'h00) begin
            // A zero byte while idle ends the string early.
            if (c == 8'h00) begin
                put_term();
                if (bt.in_last)
                    clear_string();
                else
                    skipping = 1'b1;
                return;
            end
            if (c < 8'h80)
                put_char(c);
            else
                pend_lead = c;
        end else begin
            lead      = pend_lead;
            pend_lead = '0;
            if (lead == LEAD_D0) begin
                if (c >= 8'h90 && c < 8'hD0)
                    put_char(c + OFS_D0);
                else if (c == YO_UP_TR)
                    put_char(CP_YO_UP);
                else
                    put_char(c);
            end else if (lead == LEAD_D1) begin
                if (c >= 8'h80 && c < 8'h90)
                    put_char(c + OFS_D1);
                else if (c == YO_LO_TR)
                    put_char(CP_YO_LO);
                else
                    put_char(c);
            end else if (lead == LEAD_C2) begin
                if (c == GUIL_LEFT || c == GUIL_RIGHT)
                    put_char(CH_QUOTE);
                else
                    put_char(unknown_reg);
            end else if (lead == LEAD_E2) begin
                pend_lead  = lead;
                held_trail = c;
                e2_phase   = E2_HELD;
            end else begin
                put_char(unknown_reg);
            end
        end
        if (bt.in_last) begin
            put_term();
            clear_string();
        end
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic last);
        t_in_beat bt;
        bt.in_byte = b;
        bt.in_last = last;
        src_pending.push_back(bt);
    endfunction

    // Builds one random source string and returns its length in beats.
    function automatic int queue_string();
        logic [7:0] seq[$];
        int nchar;
        int k;
        int pick;
        int sub;
        nchar = $urandom_range(1, 14);
        for (k = 0; k < nchar; k++) begin
            pick = $urandom_range(0, 99);
            sub  = $urandom_range(0, 9);
            if (pick < 30) begin
                seq.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 45) begin
                seq.push_back(LEAD_D0);
                seq.push_back(sub < 7 ? 8'($urandom_range(8'h90, 8'hCF)) :
                              sub < 8 ? YO_UP_TR : 8'($urandom_range(0, 255)));
            end else if (pick < 58) begin
                seq.push_back(LEAD_D1);
                seq.push_back(sub < 7 ? 8'($urandom_range(8'h80, 8'h8F)) :
                              sub < 8 ? YO_LO_TR : 8'($urandom_range(0, 255)));
            end else if (pick < 66) begin
                seq.push_back(LEAD_C2);
                seq.push_back(sub < 4 ? GUIL_LEFT : sub < 8 ? GUIL_RIGHT :
                              8'($urandom_range(0, 255)));
            end else if (pick < 76) begin
                seq.push_back(LEAD_E2);
                if (sub < 8) begin
                    seq.push_back(TRAIL_E2_1);
                    seq.push_back(sub < 4 ? TRAIL_DASH : TRAIL_ELL);
                end else begin
                    seq.push_back(8'($urandom_range(0, 255)));
                    seq.push_back(8'($urandom_range(0, 255)));
                end
            end else if (pick < 84) begin
                seq.push_back(8'($urandom_range(8'h80, 8'hFF)));
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                seq.push_back(8'h00);
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Now and then the string stops in the middle of a sequence.
        if ($urandom_range(0, 9) == 0) begin
            seq.push_back($urandom_range(0, 1) ? LEAD_E2 : 8'($urandom_range(8'h80, 8'hFF)));
            if ($urandom_range(0, 1))
                seq.push_back(TRAIL_E2_1);
        end
        for (k = 0; k < seq.size(); k++)
            push_beat(seq[k], k == seq.size() - 1);
        return seq.size();
    endfunction

    // Driver: presents queued source beats, with random gaps between them outside the calm window.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                transcode_beat(in_beat);
            if (!in_valid || in_ready) begin
                if (src_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
                    in_valid <= 1'b1;
                    in_beat  <= src_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted output beat against the oldest expectation.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (cp_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte %02h last %0b",
                                              out_beat.out_byte, out_beat.out_last));
                end else begin
                    want_beat = cp_expected.pop_front();
                    if (out_beat.out_byte !== want_beat.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_beat.out_byte, want_beat.out_byte));
                    if (out_beat.out_last !== want_beat.out_last)
                        report_mismatch($sformatf("out_last %0b, expected %0b",
                                                  out_beat.out_last, want_beat.out_last));
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // Writes one register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_OUT_LIMIT)
            limit_reg = val;
        else if (idx == CFG_UNKNOWN_CHAR)
            unknown_reg = val[7:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every beat is sent and every result has come, then lets the pipe drain.
    task automatic settle();
        while (src_pending.size() != 0 || in_valid || cp_expected.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial begin
        int ph;
        int queued;
        int quota;
        logic [LIMIT_W-1:0] lim_pick;
        logic [7:0] unk_pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings under the reset configuration.
        push_beat(8'h41, 1'b0);
        push_beat(LEAD_D0, 1'b0); push_beat(8'h90, 1'b0);
        push_beat(LEAD_D0, 1'b0); push_beat(YO_UP_TR, 1'b0);
        push_beat(LEAD_D0, 1'b0); push_beat(8'h80, 1'b0);
        push_beat(LEAD_D1, 1'b0); push_beat(8'h8F, 1'b0);
        push_beat(LEAD_D1, 1'b0); push_beat(YO_LO_TR, 1'b0);
        push_beat(LEAD_D1, 1'b0); push_beat(8'h00, 1'b0);
        push_beat(LEAD_C2, 1'b0); push_beat(GUIL_LEFT, 1'b0);
        push_beat(LEAD_C2, 1'b0); push_beat(8'hA0, 1'b0);
        push_beat(LEAD_E2, 1'b0); push_beat(TRAIL_E2_1, 1'b0); push_beat(TRAIL_DASH, 1'b0);
        push_beat(LEAD_E2, 1'b0); push_beat(8'h81, 1'b0); push_beat(TRAIL_ELL, 1'b0);
        push_beat(8'hFF, 1'b0); push_beat(8'h7F, 1'b0);
        // Early zero terminator, then a skipped byte that closes the string.
        push_beat(8'h00, 1'b0); push_beat(8'h55, 1'b1);
        push_beat(LEAD_E2, 1'b0); push_beat(TRAIL_E2_1, 1'b0); push_beat(TRAIL_ELL, 1'b1);
        push_beat(8'h00, 1'b1);
        settle();

        // Random strings under several register settings, extremes first.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    lim_pick = 13'd1;
                    unk_pick = 8'h00;
                    quota    = 40;
                end
                1: begin
                    lim_pick = 13'd4096;
                    unk_pick = 8'hFF;
                    quota    = 90;
                end
                2: begin
                    lim_pick = LIMIT_W'($urandom_range(2, 9));
                    unk_pick = 8'($urandom_range(0, 255));
                    quota    = 100;
                end
                default: begin
                    lim_pick = LIMIT_W'($urandom_range(1, 64));
                    unk_pick = 8'($urandom_range(0, 255));
                    quota    = 100;
                end
            endcase
            write_reg(CFG_OUT_LIMIT, lim_pick);
            write_reg(CFG_UNKNOWN_CHAR, LIMIT_W'(unk_pick));
            queued = 0;
            while (queued < quota)
                queued += queue_string();
            settle();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
